### hw/rtl/sha512_pkg.sv
// shared types, constants and round functions for the sha-512 byte hasher
package sha512_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef logic [63:0] word_t;

  typedef enum logic [0:0] {
    CmdData   = 1'b0,
    CmdFinish = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLen,
    StRound,
    StAdd,
    StOut
  } core_state_e;

  localparam word_t [7:0] InitHash = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic word_t round_const(input logic [6:0] t);
    word_t k;
    unique case (t)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

### hw/rtl/sha512_front.sv
// input queue: accepts and classifies bytes ahead of the compression core
module sha512_front #(
  parameter int unsigned Depth = sha512_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          data_byte_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output sha512_pkg::entry_t  q_entry_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha512_pkg::entry_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic push, pop;

  assign ready_o   = (cnt_q != Depth[Aw:0]);
  assign q_valid_o = (cnt_q != '0);
  assign q_entry_o = mem_q[rd_q];
  assign push = valid_i & ready_o;
  assign pop  = q_valid_o & q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].finish <= (cmd_i == sha512_pkg::CmdFinish);
      mem_q[wr_q].data   <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Depth[Aw:0])
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push count");
endmodule

### hw/rtl/sha512_core.sv
// back end: block packing, padding, 80-round compression and digest output
module sha512_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  sha512_pkg::entry_t  q_entry_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [63:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  sha512_pkg::core_state_e state_q, state_d;

  sha512_pkg::word_t w_q [16];
  sha512_pkg::word_t h_q [8];
  sha512_pkg::word_t v_q [8];
  logic [6:0]  pos_q;
  logic [63:0] bits_q;
  logic [6:0]  rnd_q;
  logic        fin_q;   // compression belongs to the finishing sequence
  logic [2:0]  oidx_q;

  // byte written this cycle, if any
  logic       byte_we;
  logic [7:0] byte_val;
  logic       take;
  logic [6:0] pos_inc;

  assign pos_inc = pos_q + 7'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha512_pkg::StIdle:
        if (q_valid_i) begin
          if (q_entry_i.finish) state_d = sha512_pkg::StPad;
          else if (pos_q == 7'd127) state_d = sha512_pkg::StRound;
        end
      sha512_pkg::StPad:
        if (pos_q == 7'd127) state_d = sha512_pkg::StRound;
        else if (pos_inc == 7'd112) state_d = sha512_pkg::StLen;
      sha512_pkg::StLen:   state_d = sha512_pkg::StRound;
      sha512_pkg::StRound: if (rnd_q == 7'd79) state_d = sha512_pkg::StAdd;
      sha512_pkg::StAdd:
        if (!fin_q) state_d = sha512_pkg::StIdle;
        else if (pos_q == 7'd112) state_d = sha512_pkg::StOut;
        else state_d = sha512_pkg::StPad;
      sha512_pkg::StOut:
        if (ready_i && oidx_q == 3'd7) state_d = sha512_pkg::StIdle;
      default: state_d = sha512_pkg::StIdle;
    endcase
  end

  always_comb begin
    q_ready_o = 1'b0;
    byte_we   = 1'b0;
    byte_val  = 8'h00;
    valid_o   = 1'b0;
    unique case (state_q)
      sha512_pkg::StIdle: begin
        q_ready_o = 1'b1;
        byte_we   = q_valid_i & ~q_entry_i.finish;
        byte_val  = q_entry_i.data;
      end
      sha512_pkg::StPad: begin
        byte_we  = 1'b1;
        byte_val = 8'h00;
      end
      sha512_pkg::StOut: valid_o = 1'b1;
      default: ;
    endcase
  end

  assign take = q_valid_i & q_ready_o;
  assign digest_word_o = h_q[0];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // round datapath
  sha512_pkg::word_t s0, s1, wn, ch, maj, e0, e1, t1, t2;
  always_comb begin
    s1 = sha512_pkg::rotr(w_q[14], 19) ^ sha512_pkg::rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    s0 = sha512_pkg::rotr(w_q[1], 1) ^ sha512_pkg::rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    wn = s1 + w_q[9] + s0 + w_q[0];
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    e1 = sha512_pkg::rotr(v_q[4], 14) ^ sha512_pkg::rotr(v_q[4], 18)
       ^ sha512_pkg::rotr(v_q[4], 41);
    e0 = sha512_pkg::rotr(v_q[0], 28) ^ sha512_pkg::rotr(v_q[0], 34)
       ^ sha512_pkg::rotr(v_q[0], 39);
    t1 = v_q[7] + e1 + ch + sha512_pkg::round_const(rnd_q) + w_q[0];
    t2 = e0 + maj;
  end

  logic [63:0] sh_mask, sh_val;
  logic [5:0]  sh;
  assign sh      = {~pos_q[2:0], 3'b000};
  assign sh_mask = ~(64'hff << sh);
  assign sh_val  = {56'h0, byte_val} << sh;

  logic first_pad;
  assign first_pad = (state_q == sha512_pkg::StPad) && !fin_q;

  always_ff @(posedge clk_i) begin
    if (state_q == sha512_pkg::StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end else if (state_q == sha512_pkg::StLen) begin
      w_q[14] <= '0;
      w_q[15] <= bits_q;
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (byte_we || first_pad) begin
      // first pad cycle writes the 0x80 marker
      w_q[pos_q[6:3]] <= (w_q[pos_q[6:3]] & sh_mask)
                       | (first_pad ? (64'h80 << sh) : sh_val);
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::StIdle;
      for (int i = 0; i < 8; i++) h_q[i] <= sha512_pkg::InitHash[i];
      pos_q  <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      fin_q  <= 1'b0;
      oidx_q <= '0;
    end else begin
      state_q <= state_d;
      if (take && !q_entry_i.finish) bits_q <= bits_q + 64'd8;
      if (byte_we || state_q == sha512_pkg::StPad) pos_q <= pos_inc;
      if (state_q == sha512_pkg::StPad) fin_q <= 1'b1;
      if (state_q == sha512_pkg::StRound) rnd_q <= rnd_q + 7'd1;
      else rnd_q <= '0;
      if (state_q == sha512_pkg::StAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        if (!fin_q) pos_q <= '0;
      end
      if (state_q == sha512_pkg::StLen) pos_q <= 7'd112;
      if (state_q == sha512_pkg::StOut && ready_i) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
        h_q[7] <= sha512_pkg::InitHash[oidx_q];
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          pos_q  <= '0;
          bits_q <= '0;
          fin_q  <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == sha512_pkg::StOut) else $error("output outside drain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && last_word_o) |=> state_q == sha512_pkg::StIdle)
    else $error("no return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> oidx_q == 3'd0) else $error("accept during drain");
endmodule

### hw/rtl/sha512_byte_stream_hasher.sv
// sha-512 byte stream hasher: input queue feeding the compression core
// a byte is registered in the queue, then packed into the block buffer; a full block runs the
// rounds and the add. finish: pad up to byte 112, length, rounds and add, plus pad to block
// end and another compression if padding spills into an extra block; then 8 digest words,
// one per cycle while ready_i is high. no byte is taken while the round unit compresses.
// reset clears queue, counters and loads the initial hash; buffer needs no reset
module sha512_byte_stream_hasher #(
  parameter int unsigned QueueDepth = sha512_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  logic q_valid, q_ready;
  sha512_pkg::entry_t q_entry;

  sha512_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .cmd_i, .data_byte_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_entry_o(q_entry)
  );

  sha512_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_entry_i(q_entry),
    .valid_o, .ready_i, .digest_word_o, .word_index_o, .last_word_o
  );
endmodule
